// File: src/bsig_pkg.sv
// ---------------------------------------------------------------------------
// bsig_pkg
// Shared widths and register codes of the broadcast stride index generator.
// ---------------------------------------------------------------------------
`default_nettype none
package bsig_pkg;

    localparam int FIELD_W = 32;
    localparam int CFG_W   = 64;
    localparam int RANK_W  = 3;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANK     = 2'd0,
        REG_EXTENTS  = 2'd1,
        REG_STRIDE_A = 2'd2,
        REG_STRIDE_B = 2'd3
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] EXTENTS_RESET = 64'h0001_0001_0001_0001;
    localparam logic [RANK_W-1:0] RANK_RESET   = 3'd1;

endpackage
`default_nettype wire

// File: src/bsig_div_cell.sv
// ---------------------------------------------------------------------------
// bsig_div_cell
// One restoring division step; carries the request's payload to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none
module bsig_div_cell #(
    parameter int IB = 32,
    parameter int DB = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic [DB-1:0] ext,
    input  wire logic          v_in,
    input  wire logic [IB-1:0] work_in,
    input  wire logic [DB-1:0] rem_in,
    input  wire logic [IB-1:0] idx_in,
    input  wire logic [IB-1:0] a1_in,
    input  wire logic [IB-1:0] a2_in,
    output logic               v_out,
    output logic      [IB-1:0] work_out,
    output logic      [DB-1:0] rem_out,
    output logic      [IB-1:0] idx_out,
    output logic      [IB-1:0] a1_out,
    output logic      [IB-1:0] a2_out
);

    logic          v_reg;
    logic [IB-1:0] work_reg, work_next;
    logic [DB-1:0] rem_reg, rem_next;
    logic [IB-1:0] idx_reg, a1_reg, a2_reg;
    logic [DB:0]   trial;
    logic [DB:0]   diff;
    logic          ge;

    always_comb
    begin
        trial     = {rem_in, work_in[IB-1]};
        ge        = (trial >= {1'b0, ext});
        diff      = trial - {1'b0, ext};
        rem_next  = ge ? diff[DB-1:0] : trial[DB-1:0];
        work_next = {work_in[IB-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
            idx_reg  <= idx_in;
            a1_reg   <= a1_in;
            a2_reg   <= a2_in;
        end
    end

    assign v_out    = v_reg;
    assign work_out = work_reg;
    assign rem_out  = rem_reg;
    assign idx_out  = idx_reg;
    assign a1_out   = a1_reg;
    assign a2_out   = a2_reg;

endmodule
`default_nettype wire

// File: src/bsig_dim.sv
// ---------------------------------------------------------------------------
// bsig_dim
// One dimension: a chain of division cells, then a multiply and accumulate.
// ---------------------------------------------------------------------------
`default_nettype none
module bsig_dim #(
    parameter int IB = 32,
    parameter int DB = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic [DB-1:0] ext,
    input  wire logic [DB-1:0] stride_a,
    input  wire logic [DB-1:0] stride_b,
    input  wire logic          v_in,
    input  wire logic [IB-1:0] rest_in,
    input  wire logic [IB-1:0] idx_in,
    input  wire logic [IB-1:0] a1_in,
    input  wire logic [IB-1:0] a2_in,
    output logic               v_out,
    output logic      [IB-1:0] rest_out,
    output logic      [IB-1:0] idx_out,
    output logic      [IB-1:0] a1_out,
    output logic      [IB-1:0] a2_out
);

    localparam int PW = 2 * DB;
    localparam int SW = (PW > IB) ? PW : IB;

    logic          cv    [IB+1];
    logic [IB-1:0] cwork [IB+1];
    logic [DB-1:0] crem  [IB+1];
    logic [IB-1:0] cidx  [IB+1];
    logic [IB-1:0] ca1   [IB+1];
    logic [IB-1:0] ca2   [IB+1];

    assign cv[0]    = v_in;
    assign cwork[0] = rest_in;
    assign crem[0]  = '0;
    assign cidx[0]  = idx_in;
    assign ca1[0]   = a1_in;
    assign ca2[0]   = a2_in;

    for (genvar i = 0; i < IB; i++)
    begin : g_cell
        bsig_div_cell #(.IB(IB), .DB(DB)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ext      (ext),
            .v_in     (cv[i]),
            .work_in  (cwork[i]),
            .rem_in   (crem[i]),
            .idx_in   (cidx[i]),
            .a1_in    (ca1[i]),
            .a2_in    (ca2[i]),
            .v_out    (cv[i+1]),
            .work_out (cwork[i+1]),
            .rem_out  (crem[i+1]),
            .idx_out  (cidx[i+1]),
            .a1_out   (ca1[i+1]),
            .a2_out   (ca2[i+1])
        );
    end

    // product stage
    logic          mv_reg;
    logic [PW-1:0] p1_reg, p2_reg;
    logic [IB-1:0] mrest_reg, midx_reg, ma1_reg, ma2_reg;

    // accumulate stage
    logic          ov_reg;
    logic [IB-1:0] orest_reg, oidx_reg, oa1_reg, oa2_reg;
    logic [SW-1:0] s1_next, s2_next;

    always_comb
    begin
        s1_next = SW'(ma1_reg) + SW'(p1_reg);
        s2_next = SW'(ma2_reg) + SW'(p2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            mv_reg <= cv[IB];
            ov_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= PW'(crem[IB]) * PW'(stride_a);
            p2_reg    <= PW'(crem[IB]) * PW'(stride_b);
            mrest_reg <= cwork[IB];
            midx_reg  <= cidx[IB];
            ma1_reg   <= ca1[IB];
            ma2_reg   <= ca2[IB];
            orest_reg <= mrest_reg;
            oidx_reg  <= midx_reg;
            oa1_reg   <= s1_next[IB-1:0];
            oa2_reg   <= s2_next[IB-1:0];
        end
    end

    assign v_out    = ov_reg;
    assign rest_out = orest_reg;
    assign idx_out  = oidx_reg;
    assign a1_out   = oa1_reg;
    assign a2_out   = oa2_reg;

endmodule
`default_nettype wire

// File: src/broadcast_stride_index_generator.sv
// ---------------------------------------------------------------------------
// broadcast_stride_index_generator
// Splits a linear output index into coordinates and forms two strided indices.
// ---------------------------------------------------------------------------
// throughput: one request per cycle; the whole chain stalls while a result waits
// each dimension is a row of INDEX_BITS division cells plus multiply and add stages
// reset clears all valid bits and loads rank 1, extents 1 and zero strides
`default_nettype none
module broadcast_stride_index_generator #(
    parameter int MAX_DIMS   = 4,
    parameter int DIM_BITS   = 16,
    parameter int INDEX_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [bsig_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bsig_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire logic [bsig_pkg::FIELD_W-1:0]       out_index,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_ready,
    output logic      [bsig_pkg::FIELD_W-1:0]       dest_index,
    output logic      [bsig_pkg::FIELD_W-1:0]       first_index,
    output logic      [bsig_pkg::FIELD_W-1:0]       second_index
);

    localparam int IB = INDEX_BITS;
    localparam int DB = DIM_BITS;

    logic [bsig_pkg::RANK_W-1:0] rank_reg;
    logic [bsig_pkg::CFG_W-1:0]  extents_reg, stride_a_reg, stride_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg     <= bsig_pkg::RANK_RESET;
            extents_reg  <= bsig_pkg::EXTENTS_RESET;
            stride_a_reg <= '0;
            stride_b_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (bsig_pkg::cfg_reg_t'(cfg_index))
                bsig_pkg::REG_RANK:     rank_reg     <= cfg_data[bsig_pkg::RANK_W-1:0];
                bsig_pkg::REG_EXTENTS:  extents_reg  <= cfg_data;
                bsig_pkg::REG_STRIDE_A: stride_a_reg <= cfg_data;
                bsig_pkg::REG_STRIDE_B: stride_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    assign en        = rsp_ready || !rsp_valid;
    assign req_ready = en;

    logic          pv    [MAX_DIMS+1];
    logic [IB-1:0] prest [MAX_DIMS+1];
    logic [IB-1:0] pidx  [MAX_DIMS+1];
    logic [IB-1:0] pa1   [MAX_DIMS+1];
    logic [IB-1:0] pa2   [MAX_DIMS+1];

    assign pv[0]    = req_valid;
    assign prest[0] = out_index[IB-1:0];
    assign pidx[0]  = out_index[IB-1:0];
    assign pa1[0]   = '0;
    assign pa2[0]   = '0;

    // innermost dimension first; unused dimensions divide by one
    for (genvar j = 0; j < MAX_DIMS; j++)
    begin : g_dim
        localparam int D = MAX_DIMS - 1 - j;
        logic [DB-1:0] ext_raw, ext_eff;
        logic          in_use;

        assign ext_raw = extents_reg[D*DB +: DB];
        assign in_use  = (4'(D) < 4'(rank_reg));
        assign ext_eff = (in_use && ext_raw != '0) ? ext_raw : DB'(1);

        bsig_dim #(.IB(IB), .DB(DB)) u_dim (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ext      (ext_eff),
            .stride_a (stride_a_reg[D*DB +: DB]),
            .stride_b (stride_b_reg[D*DB +: DB]),
            .v_in     (pv[j]),
            .rest_in  (prest[j]),
            .idx_in   (pidx[j]),
            .a1_in    (pa1[j]),
            .a2_in    (pa2[j]),
            .v_out    (pv[j+1]),
            .rest_out (prest[j+1]),
            .idx_out  (pidx[j+1]),
            .a1_out   (pa1[j+1]),
            .a2_out   (pa2[j+1])
        );
    end

    assign rsp_valid    = pv[MAX_DIMS];
    assign dest_index   = bsig_pkg::FIELD_W'(pidx[MAX_DIMS]);
    assign first_index  = bsig_pkg::FIELD_W'(pa1[MAX_DIMS]);
    assign second_index = bsig_pkg::FIELD_W'(pa2[MAX_DIMS]);

    a_ready_follows_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (rsp_ready || !rsp_valid))
        else $error("request ready does not follow output stall");

    a_stall_holds_chain: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(first_index)
            && $stable(second_index))
        else $error("chain moved while result stalled");

    a_dest_width: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (bsig_pkg::FIELD_W'(dest_index >> IB) == '0))
        else $error("dest index exceeds index width");

endmodule
`default_nettype wire
